// File: sv/jpeg_header_segment_scanner_unit_macros.svh
`ifndef JPEG_HEADER_SEGMENT_SCANNER_UNIT_MACROS_SVH
`define JPEG_HEADER_SEGMENT_SCANNER_UNIT_MACROS_SVH

// Property that must hold in the same cycle as its antecedent.
`define JHSS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("Scanner assertion failed in the same cycle.");

// Property that must hold in the cycle after its antecedent.
`define JHSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("Scanner assertion failed in the following cycle.");

`endif

// File: sv/jhss_pkg.sv
package jhss_pkg;

   localparam int OFFSET_BITS = 24;
   localparam int SOF_OFFSET_BITS = 24;
   localparam int NEW_LENGTH_BITS = 25;
   localparam int CALC_BITS = (OFFSET_BITS + 1 > NEW_LENGTH_BITS) ?
                              OFFSET_BITS + 1 : NEW_LENGTH_BITS;
   localparam int DHT_TABLE_BYTES = 420;

   typedef logic [OFFSET_BITS-1:0] offset_type;
   typedef logic [CALC_BITS-1:0] calc_type;

   localparam offset_type OFFSET_MAX = '1;

   localparam logic [7:0] MARKER_PREFIX = 8'hff;
   localparam logic [7:0] MARKER_SOI = 8'hd8;
   localparam logic [7:0] MARKER_APP0 = 8'he0;
   localparam logic [7:0] MARKER_SOS = 8'hda;
   localparam logic [7:0] MARKER_DHT = 8'hc4;
   localparam logic [7:0] MARKER_SOF0 = 8'hc0;
   localparam int HEADER_BYTES = 11;

   localparam logic [2:0] ST_NEEDS_TABLE = 3'd0;
   localparam logic [2:0] ST_HAS_DHT = 3'd1;
   localparam logic [2:0] ST_SOS_NO_SOF = 3'd2;
   localparam logic [2:0] ST_NOT_JPEG = 3'd3;
   localparam logic [2:0] ST_BAD_MARKER = 3'd4;
   localparam logic [2:0] ST_TRUNCATED = 3'd5;

   typedef enum logic [7:0] {
      PH_HEAD = 8'b0000_0001,
      PH_MARK0 = 8'b0000_0010,
      PH_MARK1 = 8'b0000_0100,
      PH_LEN_HI = 8'b0000_1000,
      PH_LEN_LO = 8'b0001_0000,
      PH_SKIP = 8'b0010_0000,
      PH_PEND = 8'b0100_0000,
      PH_STOP = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic last;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic size_found;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic [SOF_OFFSET_BITS-1:0] sof_offset;
      logic [NEW_LENGTH_BITS-1:0] new_length;
   } rsp_type;

   function automatic logic [7:0] jfif_char(input logic [1:0] idx);
      logic [7:0] c;
      case (idx)
         2'd0: c = 8'h4a;
         2'd1: c = 8'h46;
         2'd2: c = 8'h49;
         default: c = 8'h46;
      endcase
      return c;
   endfunction

endpackage

// File: sv/jhss_input_reg.sv
module jhss_input_reg (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input jhss_pkg::req_type req_data,
   input logic advance,
   output logic item_valid,
   output jhss_pkg::req_type item_data
);

   logic valid_ff, valid_in;
   jhss_pkg::req_type data_ff, data_in;

   assign req_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      data_in = data_ff;
      if (req_ready) begin
         valid_in = req_valid;
         data_in = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign item_valid = valid_ff;
   assign item_data = data_ff;

endmodule

// File: sv/jhss_walker.sv
module jhss_walker (
   input logic clock,
   input logic reset,
   input logic step,
   input jhss_pkg::req_type item,
   output jhss_pkg::rsp_type result
);

   jhss_pkg::phase_type phase_ff, phase_in;
   jhss_pkg::offset_type pos_ff, pos_in;
   logic [3:0] seg_ff, seg_in;
   logic [16:0] skip_ff, skip_in;
   logic [7:0] len_high_ff, len_high_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   jhss_pkg::offset_type sof_ff, sof_in;
   logic hdr_bad_ff, hdr_bad_in;
   logic app0_ff, app0_in;
   logic size_done_ff, size_done_in;
   logic size_closed_ff, size_closed_in;
   logic [2:0] decided_ff, decided_in;
   logic fixed_ff, fixed_in;
   logic mark_ff_ff, mark_ff_in;
   logic [7:0] mark_code_ff, mark_code_in;
   logic [2:0] cap_ff, cap_in;

   always_comb begin
      logic [7:0] b;
      logic [15:0] len;
      logic failed;
      jhss_pkg::offset_type length;
      b = item.data_byte;
      len = {len_high_ff, b};
      failed = 1'b0;

      phase_in = phase_ff;
      seg_in = seg_ff;
      skip_in = skip_ff;
      len_high_in = len_high_ff;
      width_in = width_ff;
      height_in = height_ff;
      sof_in = sof_ff;
      hdr_bad_in = hdr_bad_ff;
      app0_in = app0_ff;
      size_done_in = size_done_ff;
      size_closed_in = size_closed_ff;
      decided_in = decided_ff;
      fixed_in = fixed_ff;
      mark_ff_in = mark_ff_ff;
      mark_code_in = mark_code_ff;
      cap_in = cap_ff;

      if (pos_ff == jhss_pkg::offset_type'(0) && b != jhss_pkg::MARKER_PREFIX) begin
         hdr_bad_in = 1'b1;
      end
      if (pos_ff == jhss_pkg::offset_type'(1) && b != jhss_pkg::MARKER_SOI) begin
         hdr_bad_in = 1'b1;
      end
      if (pos_ff == jhss_pkg::offset_type'(2) && b == jhss_pkg::MARKER_PREFIX) begin
         app0_in = 1'b1;
      end
      if (pos_ff == jhss_pkg::offset_type'(3) && b != jhss_pkg::MARKER_APP0) begin
         app0_in = 1'b0;
      end
      if (pos_ff >= jhss_pkg::offset_type'(6) && pos_ff <= jhss_pkg::offset_type'(9)
            && app0_in && b != jhss_pkg::jfif_char(pos_ff[1:0] - 2'd2)) begin
         hdr_bad_in = 1'b1;
      end
      if (pos_ff == jhss_pkg::offset_type'(10) && app0_in && b != 8'h00) begin
         hdr_bad_in = 1'b1;
      end

      if (cap_ff != 3'd0) begin
         case (cap_ff)
            3'd2: height_in[15:8] = b;
            3'd3: height_in[7:0] = b;
            3'd4: width_in[15:8] = b;
            3'd5: width_in[7:0] = b;
            default: ;
         endcase
         if (cap_ff >= 3'd5) begin
            size_done_in = 1'b1;
            cap_in = 3'd0;
         end else begin
            cap_in = cap_ff + 3'd1;
         end
      end

      case (phase_ff)
         jhss_pkg::PH_HEAD: begin
            if (pos_ff >= jhss_pkg::offset_type'(3)) begin
               phase_in = jhss_pkg::PH_LEN_HI;
            end
         end
         jhss_pkg::PH_MARK0: begin
            mark_ff_in = (b == jhss_pkg::MARKER_PREFIX);
            phase_in = jhss_pkg::PH_MARK1;
         end
         jhss_pkg::PH_MARK1: begin
            mark_code_in = b;
            phase_in = jhss_pkg::PH_LEN_HI;
         end
         jhss_pkg::PH_LEN_HI: begin
            len_high_in = b;
            phase_in = jhss_pkg::PH_LEN_LO;
         end
         jhss_pkg::PH_LEN_LO: begin
            if (seg_ff != 4'd0) begin
               if (!mark_ff_ff) begin
                  failed = 1'b1;
               end else if (mark_code_ff == jhss_pkg::MARKER_SOS) begin
                  if (!fixed_in) begin
                     decided_in = (sof_ff != '0) ? jhss_pkg::ST_NEEDS_TABLE :
                                                   jhss_pkg::ST_SOS_NO_SOF;
                     fixed_in = 1'b1;
                  end
               end else if (mark_code_ff == jhss_pkg::MARKER_DHT) begin
                  if (!fixed_in) begin
                     decided_in = jhss_pkg::ST_HAS_DHT;
                     fixed_in = 1'b1;
                  end
               end else if (mark_code_ff == jhss_pkg::MARKER_SOF0) begin
                  if (!fixed_in) begin
                     sof_in = pos_ff - jhss_pkg::offset_type'(3);
                  end
                  if (!size_closed_in) begin
                     size_closed_in = 1'b1;
                     cap_in = 3'd1;
                  end
               end
            end
            if (!failed) begin
               if (seg_ff < 4'd15) begin
                  seg_in = seg_ff + 4'd1;
               end
               if (fixed_in && size_closed_in) begin
                  phase_in = jhss_pkg::PH_STOP;
               end else if (len < 16'd2) begin
                  skip_in = 17'(len) + 17'd2;
                  phase_in = jhss_pkg::PH_PEND;
               end else if (len == 16'd2) begin
                  phase_in = jhss_pkg::PH_MARK0;
               end else begin
                  skip_in = 17'(len) - 17'd2;
                  phase_in = jhss_pkg::PH_SKIP;
               end
            end
         end
         jhss_pkg::PH_SKIP: begin
            if (skip_ff != 17'd0) begin
               skip_in = skip_ff - 17'd1;
            end
            if (skip_in == 17'd0) begin
               phase_in = jhss_pkg::PH_MARK0;
            end
         end
         jhss_pkg::PH_PEND: begin
            if (skip_ff != 17'd0) begin
               skip_in = skip_ff - 17'd1;
            end
            if (skip_in == 17'd0) begin
               failed = 1'b1;
            end
         end
         default: ;
      endcase

      if (failed) begin
         if (!fixed_in) begin
            decided_in = jhss_pkg::ST_BAD_MARKER;
            fixed_in = 1'b1;
         end
         size_closed_in = 1'b1;
         phase_in = jhss_pkg::PH_STOP;
      end

      length = (pos_ff < jhss_pkg::OFFSET_MAX) ? pos_ff + jhss_pkg::offset_type'(1) :
                                                jhss_pkg::OFFSET_MAX;
      pos_in = length;

      if (!hdr_bad_in && pos_ff >= jhss_pkg::offset_type'(jhss_pkg::HEADER_BYTES - 1)) begin
         result.status = fixed_in ? decided_in : jhss_pkg::ST_TRUNCATED;
         result.sof_offset = jhss_pkg::SOF_OFFSET_BITS'(jhss_pkg::calc_type'(sof_in));
      end else begin
         result.status = jhss_pkg::ST_NOT_JPEG;
         result.sof_offset = '0;
      end
      result.size_found = (result.status != jhss_pkg::ST_NOT_JPEG) && size_done_in;
      result.image_width = result.size_found ? width_in : 16'd0;
      result.image_height = result.size_found ? height_in : 16'd0;
      if (result.status == jhss_pkg::ST_NEEDS_TABLE) begin
         result.new_length = jhss_pkg::NEW_LENGTH_BITS'(jhss_pkg::calc_type'(length)
                              + jhss_pkg::calc_type'(jhss_pkg::DHT_TABLE_BYTES));
      end else begin
         result.new_length = jhss_pkg::NEW_LENGTH_BITS'(jhss_pkg::calc_type'(length));
      end

      if (item.last) begin
         phase_in = jhss_pkg::PH_HEAD;
         pos_in = '0;
         seg_in = 4'd0;
         skip_in = 17'd0;
         len_high_in = 8'd0;
         width_in = 16'd0;
         height_in = 16'd0;
         sof_in = '0;
         hdr_bad_in = 1'b0;
         app0_in = 1'b0;
         size_done_in = 1'b0;
         size_closed_in = 1'b0;
         decided_in = jhss_pkg::ST_TRUNCATED;
         fixed_in = 1'b0;
         mark_ff_in = 1'b0;
         mark_code_in = 8'd0;
         cap_in = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= jhss_pkg::PH_HEAD;
         pos_ff <= '0;
         seg_ff <= 4'd0;
         skip_ff <= 17'd0;
         len_high_ff <= 8'd0;
         width_ff <= 16'd0;
         height_ff <= 16'd0;
         sof_ff <= '0;
         hdr_bad_ff <= 1'b0;
         app0_ff <= 1'b0;
         size_done_ff <= 1'b0;
         size_closed_ff <= 1'b0;
         decided_ff <= jhss_pkg::ST_TRUNCATED;
         fixed_ff <= 1'b0;
         mark_ff_ff <= 1'b0;
         mark_code_ff <= 8'd0;
         cap_ff <= 3'd0;
      end else if (step) begin
         phase_ff <= phase_in;
         pos_ff <= pos_in;
         seg_ff <= seg_in;
         skip_ff <= skip_in;
         len_high_ff <= len_high_in;
         width_ff <= width_in;
         height_ff <= height_in;
         sof_ff <= sof_in;
         hdr_bad_ff <= hdr_bad_in;
         app0_ff <= app0_in;
         size_done_ff <= size_done_in;
         size_closed_ff <= size_closed_in;
         decided_ff <= decided_in;
         fixed_ff <= fixed_in;
         mark_ff_ff <= mark_ff_in;
         mark_code_ff <= mark_code_in;
         cap_ff <= cap_in;
      end
   end

endmodule

// File: sv/jhss_result_reg.sv
module jhss_result_reg (
   input logic clock,
   input logic reset,
   input logic load,
   input jhss_pkg::rsp_type load_data,
   output logic slot_free,
   output logic rsp_valid,
   input logic rsp_ready,
   output jhss_pkg::rsp_type rsp_data
);

   logic valid_ff, valid_in;
   jhss_pkg::rsp_type data_ff, data_in;

   assign slot_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff && !rsp_ready;
      data_in = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in = load_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data = data_ff;

endmodule

// File: sv/jpeg_header_segment_scanner_unit.sv
// JPEG header segment scanner.
// The request channel (req_valid, req_ready, req_data) carries one byte of a
// JPEG file per request, with a flag on the final byte of the file. The
// response channel (rsp_valid, rsp_ready, rsp_data) carries one result per
// file: status, image size, offset of the last SOF0 segment and the file
// length, grown by the default Huffman table size when one must be inserted.
// A byte is taken in every cycle while the input register can move on, so the
// sustained rate is one byte per clock; the per-byte state update is
// combinational logic between the input register and the result register.
// The final byte is held in the input register, and its result is then
// captured in the output register, from which it is offered.
// When the receiver stalls, the result waits in the output register and bytes
// of the next file keep flowing; only a second final byte waits until the
// pending result has been taken.
// Synchronous reset clears the valid flags of both registers and returns the scanner to the
// start of a file; the scanner also returns there by itself after each final byte.
`include "jpeg_header_segment_scanner_unit_macros.svh"

module jpeg_header_segment_scanner_unit (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input jhss_pkg::req_type req_data,
   output logic rsp_valid,
   input logic rsp_ready,
   output jhss_pkg::rsp_type rsp_data
);

   logic item_valid;
   jhss_pkg::req_type item_data;
   logic slot_free;
   logic advance;
   logic step;
   jhss_pkg::rsp_type result;

   assign advance = item_valid && (!item_data.last || slot_free);
   assign step = advance;

   jhss_input_reg u_input (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .advance(advance),
      .item_valid(item_valid),
      .item_data(item_data)
   );

   jhss_walker u_walker (
      .clock(clock),
      .reset(reset),
      .step(step),
      .item(item_data),
      .result(result)
   );

   jhss_result_reg u_result (
      .clock(clock),
      .reset(reset),
      .load(step && item_data.last),
      .load_data(result),
      .slot_free(slot_free),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   `JHSS_ASSERT_NEXT(a_last_loads_result, clock, reset, advance && item_data.last, rsp_valid)
   `JHSS_ASSERT_NEXT(a_held_item_kept, clock, reset, item_valid && !advance,
      item_valid && $stable(item_data))
   `JHSS_ASSERT_IMPLY(a_status_range, clock, reset, rsp_valid,
      rsp_data.status <= jhss_pkg::ST_TRUNCATED)
   `JHSS_ASSERT_IMPLY(a_size_needs_header, clock, reset, rsp_valid && rsp_data.size_found,
      rsp_data.status != jhss_pkg::ST_NOT_JPEG)

endmodule
